>>> rtl/elevator_group_dispatch_defines.svh
// Assertion macros used by the checker file of the dispatcher.
`ifndef ELEVATOR_GROUP_DISPATCH_DEFINES_SVH
`define ELEVATOR_GROUP_DISPATCH_DEFINES_SVH

// Concurrent assertion that is switched off while reset is low.
`define EGD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define EGD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/egd_pkg.sv
// Package of shared types, constants and helper functions for the dispatcher.
`default_nettype none
package egd_pkg;

    localparam int NumCars = 4;
    localparam int FloorW  = 6;

    typedef logic [FloorW-1:0] floor_t;
    typedef logic [1:0]        car_id_t;

    localparam floor_t TopFloorReset = 6'd20;

    localparam car_id_t CAR0 = 2'd0;
    localparam car_id_t CAR1 = 2'd1;
    localparam car_id_t CAR2 = 2'd2;
    localparam car_id_t CAR3 = 2'd3;

    typedef enum logic {
        ACT_CALL = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    typedef struct packed {
        action_t action;
        floor_t  call_floor;
        floor_t  dest_floor;
    } egd_item_t;

    typedef struct packed {
        car_id_t                   chosen_car;
        floor_t [NumCars-1:0]      car_floor;
        logic   [NumCars-1:0]      moving_mask;
    } egd_result_t;

    function automatic floor_t floor_dist(input floor_t a, input floor_t b);
        floor_dist = (a > b) ? floor_t'(a - b) : floor_t'(b - a);
    endfunction

    function automatic floor_t sat_floor(input floor_t v, input floor_t top);
        sat_floor = (v > top) ? top : v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/egd_pick.sv
// Car selection for a call: nearest-car compare over the parity candidates.
`default_nettype none
module egd_pick
    import egd_pkg::*;
(
    input  floor_t [NumCars-1:0] car_floor,
    input  floor_t               call_floor,
    input  floor_t               dest_floor,
    output car_id_t              chosen_car
);

    floor_t  dist0;
    floor_t  dist_mid;
    floor_t  dist3;
    floor_t  best_dist;
    car_id_t mid_car;

    always_comb begin
        mid_car   = call_floor[0] ? CAR1 : CAR2;
        dist0     = floor_dist(car_floor[CAR0], call_floor);
        dist_mid  = floor_dist(car_floor[mid_car], call_floor);
        dist3     = floor_dist(car_floor[CAR3], call_floor);
        best_dist = dist0;
        chosen_car = CAR0;
        if (call_floor[0] == dest_floor[0]) begin
            // strict compare keeps ties with the earlier car
            if (dist_mid < best_dist) begin
                best_dist  = dist_mid;
                chosen_car = mid_car;
            end
            if (dist3 < best_dist) begin
                chosen_car = CAR3;
            end
        end else if (dist3 < dist0) begin
            chosen_car = CAR3;
        end
    end

endmodule
`default_nettype wire

>>> rtl/egd_cars.sv
// Car state registers with the call assignment and tick movement update.
`default_nettype none
module egd_cars
    import egd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_fire,
    input  egd_item_t   item,
    output egd_result_t result
);

    floor_t [NumCars-1:0] floor_reg,   floor_next;
    floor_t [NumCars-1:0] target_reg,  target_next;
    floor_t [NumCars-1:0] pending_reg, pending_next;
    car_id_t              pick_car;

    egd_pick u_pick (
        .car_floor  (floor_reg),
        .call_floor (item.call_floor),
        .dest_floor (item.dest_floor),
        .chosen_car (pick_car)
    );

    always_comb begin
        floor_next   = floor_reg;
        target_next  = target_reg;
        pending_next = pending_reg;
        result.chosen_car = CAR0;
        if (item_fire) begin
            if (item.action == ACT_CALL) begin
                result.chosen_car      = pick_car;
                pending_next[pick_car] = item.dest_floor;
                target_next[pick_car]  = (floor_reg[pick_car] == item.call_floor) ?
                                         item.dest_floor : item.call_floor;
            end else begin
                for (int n = 0; n < NumCars; n++) begin
                    if (target_reg[n] > floor_reg[n]) begin
                        floor_next[n] = floor_reg[n] + floor_t'(1);
                    end else if (target_reg[n] < floor_reg[n]) begin
                        floor_next[n] = floor_reg[n] - floor_t'(1);
                    end
                    // arrived: switch to the pending destination
                    if (floor_next[n] == target_reg[n] && pending_reg[n] != target_reg[n]) begin
                        target_next[n] = pending_reg[n];
                    end
                end
            end
        end
        for (int n = 0; n < NumCars; n++) begin
            result.car_floor[n]   = floor_next[n];
            result.moving_mask[n] = (floor_next[n] != target_next[n]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= '0;
            target_reg  <= '0;
            pending_reg <= '0;
        end else begin
            floor_reg   <= floor_next;
            target_reg  <= target_next;
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/egd_outq.sv
// Result register with a skid entry so results can wait without stalling input.
`default_nettype none
module egd_outq
    import egd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  egd_result_t push_data,
    output logic        space,
    output logic        m_valid,
    input  logic        m_ready,
    output egd_result_t m_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    egd_result_t main_reg,       main_next;
    egd_result_t skid_reg,       skid_next;
    logic        pop;

    assign space   = !skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;
    assign pop     = main_valid_reg && m_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule
`default_nettype wire

>>> rtl/elevator_group_dispatch.sv
// Top level of the four-car group dispatcher.
// One word is accepted per clock when the result side keeps up. An accepted
// word waits in the input register until the result buffer has room. Its
// result word is then loaded into the result register, or into the skid entry
// if that register is still held; the m_ ports show the result register. The
// rate is set by the combinational car update: the nearest-car compare and all
// four floor steps finish between the input register and the car state, so the
// next word always sees the state left by the one before it. A two-entry result
// buffer (result register plus skid entry) lets input words keep flowing while a
// finished result waits for m_ready; s_ready drops only when both entries are
// full and the input register is also held. Caller and destination floors are
// saturated to top_floor as they are captured. top_floor resets to 20 and is
// written through cfg_we/cfg_wdata only while idle, which the user must ensure.
`default_nettype none
module elevator_group_dispatch
    import egd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic [5:0]   cfg_wdata,
    // input words
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_action,
    input  logic [5:0]   s_call_floor,
    input  logic [5:0]   s_dest_floor,
    // result words
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_chosen_car,
    output logic [5:0]   m_car0_floor,
    output logic [5:0]   m_car1_floor,
    output logic [5:0]   m_car2_floor,
    output logic [5:0]   m_car3_floor,
    output logic [3:0]   m_moving_mask
);

    floor_t      top_floor_reg;
    logic        in_valid_reg, in_valid_next;
    egd_item_t   item_reg,     item_next;
    logic        q_space;
    logic        item_fire;
    logic        s_fire;
    egd_result_t step_result;
    egd_result_t out_result;

    // advance the held word whenever the result buffer has room
    assign item_fire = in_valid_reg && q_space;
    assign s_ready   = !in_valid_reg || q_space;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_fire) begin
            in_valid_next        = 1'b1;
            item_next.action     = action_t'(s_action);
            item_next.call_floor = sat_floor(s_call_floor, top_floor_reg);
            item_next.dest_floor = sat_floor(s_dest_floor, top_floor_reg);
        end else if (item_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_floor_reg <= TopFloorReset;
            in_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                top_floor_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
        end
        item_reg <= item_next;
    end

    egd_cars u_cars (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_fire (item_fire),
        .item      (item_reg),
        .result    (step_result)
    );

    egd_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_fire),
        .push_data (step_result),
        .space     (q_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_result)
    );

    assign m_chosen_car  = out_result.chosen_car;
    assign m_car0_floor  = out_result.car_floor[0];
    assign m_car1_floor  = out_result.car_floor[1];
    assign m_car2_floor  = out_result.car_floor[2];
    assign m_car3_floor  = out_result.car_floor[3];
    assign m_moving_mask = out_result.moving_mask;

endmodule
`default_nettype wire

>>> rtl/egd_checker.sv
// Port-level checker for the dispatcher and its bind to the top level.
`default_nettype none
`include "elevator_group_dispatch_defines.svh"
module egd_checker
    import egd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_ready,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [5:0] m_car0_floor,
    input  logic [5:0] m_car1_floor,
    input  logic [5:0] m_car2_floor,
    input  logic [5:0] m_car3_floor
);

    floor_t [NumCars-1:0] cur_floor;
    floor_t [NumCars-1:0] prev_floor_reg;
    logic                 have_prev_reg;
    logic                 step_ok;
    logic                 m_fire;

    assign m_fire    = m_valid && m_ready;
    assign cur_floor = {m_car3_floor, m_car2_floor, m_car1_floor, m_car0_floor};

    // cars move one floor per tick at most, so delivered floors change by at most one
    always_comb begin
        step_ok = 1'b1;
        for (int n = 0; n < NumCars; n++) begin
            if (floor_dist(cur_floor[n], prev_floor_reg[n]) > floor_t'(1)) begin
                step_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (m_fire) begin
            have_prev_reg <= 1'b1;
        end
        if (m_fire) begin
            prev_floor_reg <= cur_floor;
        end
    end

    `EGD_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")
    `EGD_ASSERT(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")
    `EGD_ASSERT(a_stall_cause, aclk, aresetn, !s_ready |-> m_valid, "input stalled with no result")
    `EGD_ASSERT(a_floor_step, aclk, aresetn, m_fire && have_prev_reg |-> step_ok, "car jumped")

endmodule

bind elevator_group_dispatch egd_checker u_egd_checker (.*);
`default_nettype wire
